// ===== design/rus_pkg.sv =====
// Shared types, register codes and request builders for the card UID read sequencer.
// No dependencies; used by rus_ctrl and rfid_uid_read_sequencer_top.
package rus_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  addr_byte;
    logic [7:0]  write_data;
    logic        success;
    logic [2:0]  status;
    logic [31:0] card_uid;
  } out_item_t;

  // Request commands
  localparam logic [1:0] CMD_START = 2'd0;
  localparam logic [1:0] CMD_DONE  = 2'd1;
  localparam logic [1:0] CMD_TICK  = 2'd2;

  // Result kinds
  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  // Finish status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ERR_FLAGS = 3'd1;
  localparam logic [2:0] ST_BAD_LEVEL = 3'd2;
  localparam logic [2:0] ST_FEW_BITS  = 3'd3;
  localparam logic [2:0] ST_BAD_CHECK = 3'd4;

  // Reader chip registers
  localparam logic [5:0] REG_COMMAND   = 6'h01;
  localparam logic [5:0] REG_COMIRQ    = 6'h04;
  localparam logic [5:0] REG_ERROR     = 6'h06;
  localparam logic [5:0] REG_FIFODATA  = 6'h09;
  localparam logic [5:0] REG_FIFOLEVEL = 6'h0A;
  localparam logic [5:0] REG_CONTROL   = 6'h0C;
  localparam logic [5:0] REG_BITFRAME  = 6'h0D;

  // Data bytes and masks
  localparam logic [7:0] CMD_IDLE_BYTE   = 8'h00;
  localparam logic [7:0] CMD_TRANSCEIVE  = 8'h0C;
  localparam logic [7:0] IRQ_CLEAR_ALL   = 8'h7F;
  localparam logic [7:0] FLUSH_BIT       = 8'h80;
  localparam logic [7:0] START_SEND_MASK = 8'h7F;
  localparam logic [7:0] IRQ_RX_IDLE     = 8'h30;
  localparam logic [7:0] ERR_MASK        = 8'h1B;
  localparam logic [7:0] BITFRAME_SHORT  = 8'h07;
  localparam logic [7:0] BITFRAME_FULL   = 8'h00;
  localparam logic [7:0] REQA_BYTE       = 8'h26;
  localparam logic [7:0] SEL_CL1_BYTE    = 8'h93;
  localparam logic [7:0] NVB_BYTE        = 8'h20;
  localparam logic [7:0] LAST_BITS_MASK  = 8'h07;

  localparam logic [7:0] POLL_LIMIT_RESET = 8'd25;
  localparam logic [7:0] POLL_COUNT_MAX   = 8'd255;
  localparam logic [7:0] REQA_MIN_BITS    = 8'd16;
  localparam logic [7:0] UID_MIN_BITS     = 8'd40;

  // Reply bytes kept: four UID bytes plus the check byte
  localparam int UID_BYTES = 5;

  typedef enum logic [4:0] {
    P_IDLE, P_BF_SET, P_CMD_IDLE, P_IRQ_CLR, P_FL_RD, P_FL_WR, P_DATA_WR,
    P_CMD_TX, P_BF_RD1, P_BF_WR1, P_IRQ_RD, P_TICK, P_BF_RD2, P_BF_WR2,
    P_ERR_RD, P_FL_RD2, P_CTRL_RD, P_DATA_RD
  } phase_t;

  function automatic out_item_t mk_access(logic rd, logic [5:0] regn, logic [7:0] data);
    out_item_t o;
    o            = '0;
    o.kind       = rd ? KIND_READ : KIND_WRITE;
    o.addr_byte  = {rd, regn, 1'b0};
    o.write_data = rd ? 8'h00 : data;
    return o;
  endfunction

  function automatic out_item_t mk_finish(logic [2:0] code, logic [31:0] uid);
    out_item_t o;
    o          = '0;
    o.kind     = KIND_FINISH;
    o.success  = (code == ST_OK);
    o.status   = code;
    o.card_uid = (code == ST_OK) ? uid : 32'h0;
    return o;
  endfunction

endpackage

// ===== design/rfid_uid_read_sequencer_top.sv =====
// Top level: configuration register, step logic and the result register.
// Depends on rus_pkg and rus_ctrl.

// Card UID read sequencer. A start request launches REQA and the cascade
// level 1 anticollision exchange; every following request (access finished
// or poll tick) yields at most one result: the next reader register access or
// the final UID/status. The block takes one request per cycle; the only thing
// that holds in_ready low is an untaken result sitting in the output register
// while out_ready is low. poll_limit is written through cfg_we/cfg_wdata; the
// user must write it only while the sequencer is idle; no check enforces it.
module rfid_uid_read_sequencer_top #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rus_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rus_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_wdata
);
  import rus_pkg::*;

  logic       poll_limit_r;
  logic [7:0] poll_limit_q_r;
  logic       out_valid_r;
  out_item_t  out_data_r;
  logic       accept;
  logic       res_valid;
  out_item_t  res_item;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // poll_limit_r marks a register that has been loaded since reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r   <= 1'b0;
      poll_limit_q_r <= POLL_LIMIT_RESET;
    end else if (cfg_we) begin
      poll_limit_r   <= 1'b1;
      poll_limit_q_r <= cfg_wdata;
    end
  end

  rus_ctrl #(
    .FIFO_DEPTH(FIFO_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_en   (accept),
    .step_item (in_data),
    .poll_limit(poll_limit_r ? poll_limit_q_r : POLL_LIMIT_RESET),
    .res_valid (res_valid),
    .res_item  (res_item)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (accept && res_valid) begin
      out_data_r <= res_item;
    end
  end

endmodule

// ===== design/rus_ctrl.sv =====
// Sequencer state and combinational step logic: one request in, at most one result out.
// Depends on rus_pkg.
module rus_ctrl #(
  parameter int FIFO_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  rus_pkg::in_item_t step_item,
  input  logic [7:0]        poll_limit,
  output logic              res_valid,
  output rus_pkg::out_item_t res_item
);
  import rus_pkg::*;

  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int BW = CW + 3;

  phase_t         phase_r, phase_nxt;
  logic           anticoll_r, anticoll_nxt;
  logic [7:0]     poll_count_r, poll_count_nxt;
  logic [CW-1:0]  byte_index_r, byte_index_nxt;
  logic [CW-1:0]  fifo_count_r, fifo_count_nxt;
  logic [7:0]     received_bits_r, received_bits_nxt;
  logic [7:0]     buf_r [UID_BYTES];
  logic [7:0]     buf_view [UID_BYTES];
  logic           buf_we;
  logic [7:0]     rd;
  logic [BW-1:0]  bits;
  logic [CW:0]    index_inc;
  logic [7:0]     chk;

  assign rd        = step_item.read_data;
  assign buf_we    = step_en && (step_item.command == CMD_DONE) && (phase_r == P_DATA_RD) &&
                     (32'(byte_index_r) < UID_BYTES);
  assign index_inc = {1'b0, byte_index_r} + 1'b1;
  assign bits      = {fifo_count_r, 3'b000} -
                     ((rd[2:0] != 3'd0) ? BW'(4'd8 - {1'b0, rd[2:0]}) : BW'(0));

  // Buffer as it stands after this request's write
  always_comb begin
    for (int i = 0; i < UID_BYTES; i++) begin
      buf_view[i] = (buf_we && (32'(byte_index_r) == i)) ? rd : buf_r[i];
    end
  end

  assign chk = buf_view[0] ^ buf_view[1] ^ buf_view[2] ^ buf_view[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= P_IDLE;
      anticoll_r      <= 1'b0;
      poll_count_r    <= '0;
      byte_index_r    <= '0;
      fifo_count_r    <= '0;
      received_bits_r <= '0;
    end else begin
      phase_r         <= phase_nxt;
      anticoll_r      <= anticoll_nxt;
      poll_count_r    <= poll_count_nxt;
      byte_index_r    <= byte_index_nxt;
      fifo_count_r    <= fifo_count_nxt;
      received_bits_r <= received_bits_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < UID_BYTES; i++) begin
      if (buf_we && (32'(byte_index_r) == i)) begin
        buf_r[i] <= rd;
      end
    end
  end

  always_comb begin
    phase_nxt         = phase_r;
    anticoll_nxt      = anticoll_r;
    poll_count_nxt    = poll_count_r;
    byte_index_nxt    = byte_index_r;
    fifo_count_nxt    = fifo_count_r;
    received_bits_nxt = received_bits_r;
    res_valid         = 1'b0;
    res_item          = '0;

    if (step_en) begin
      case (step_item.command)
        CMD_START: begin
          if (phase_r == P_IDLE) begin
            anticoll_nxt   = 1'b0;
            poll_count_nxt = '0;
            byte_index_nxt = '0;
            phase_nxt      = P_BF_SET;
            res_valid      = 1'b1;
            res_item       = mk_access(1'b0, REG_BITFRAME, BITFRAME_SHORT);
          end
        end
        CMD_TICK: begin
          if (phase_r == P_TICK) begin
            res_valid = 1'b1;
            if (poll_count_r < poll_limit) begin
              phase_nxt = P_IRQ_RD;
              res_item  = mk_access(1'b1, REG_COMIRQ, 8'h00);
            end else begin
              phase_nxt = P_BF_RD2;
              res_item  = mk_access(1'b1, REG_BITFRAME, 8'h00);
            end
          end
        end
        CMD_DONE: begin
          res_valid = 1'b1;
          case (phase_r)
            P_BF_SET: begin
              phase_nxt = P_CMD_IDLE;
              res_item  = mk_access(1'b0, REG_COMMAND, CMD_IDLE_BYTE);
            end
            P_CMD_IDLE: begin
              phase_nxt = P_IRQ_CLR;
              res_item  = mk_access(1'b0, REG_COMIRQ, IRQ_CLEAR_ALL);
            end
            P_IRQ_CLR: begin
              phase_nxt = P_FL_RD;
              res_item  = mk_access(1'b1, REG_FIFOLEVEL, 8'h00);
            end
            P_FL_RD: begin
              phase_nxt = P_FL_WR;
              res_item  = mk_access(1'b0, REG_FIFOLEVEL, rd | FLUSH_BIT);
            end
            P_FL_WR: begin
              byte_index_nxt = CW'(1);
              phase_nxt      = P_DATA_WR;
              res_item       = mk_access(1'b0, REG_FIFODATA,
                                         anticoll_r ? SEL_CL1_BYTE : REQA_BYTE);
            end
            P_DATA_WR: begin
              // Anticollision frame has a second byte; REQA has one
              if (anticoll_r && (byte_index_r < CW'(2))) begin
                byte_index_nxt = byte_index_r + 1'b1;
                res_item       = mk_access(1'b0, REG_FIFODATA,
                                           (byte_index_r == '0) ? SEL_CL1_BYTE : NVB_BYTE);
              end else begin
                phase_nxt = P_CMD_TX;
                res_item  = mk_access(1'b0, REG_COMMAND, CMD_TRANSCEIVE);
              end
            end
            P_CMD_TX: begin
              phase_nxt = P_BF_RD1;
              res_item  = mk_access(1'b1, REG_BITFRAME, 8'h00);
            end
            P_BF_RD1: begin
              phase_nxt = P_BF_WR1;
              res_item  = mk_access(1'b0, REG_BITFRAME, rd | FLUSH_BIT);
            end
            P_BF_WR1: begin
              poll_count_nxt = '0;
              if (poll_limit != 8'd0) begin
                phase_nxt = P_IRQ_RD;
                res_item  = mk_access(1'b1, REG_COMIRQ, 8'h00);
              end else begin
                phase_nxt = P_BF_RD2;
                res_item  = mk_access(1'b1, REG_BITFRAME, 8'h00);
              end
            end
            P_IRQ_RD: begin
              if ((rd & IRQ_RX_IDLE) != 8'h00) begin
                phase_nxt = P_BF_RD2;
                res_item  = mk_access(1'b1, REG_BITFRAME, 8'h00);
              end else begin
                // No flag yet: wait for a tick before the next poll
                if (poll_count_r < POLL_COUNT_MAX) begin
                  poll_count_nxt = poll_count_r + 1'b1;
                end
                phase_nxt = P_TICK;
                res_valid = 1'b0;
              end
            end
            P_BF_RD2: begin
              phase_nxt = P_BF_WR2;
              res_item  = mk_access(1'b0, REG_BITFRAME, rd & START_SEND_MASK);
            end
            P_BF_WR2: begin
              phase_nxt = P_ERR_RD;
              res_item  = mk_access(1'b1, REG_ERROR, 8'h00);
            end
            P_ERR_RD: begin
              if ((rd & ERR_MASK) != 8'h00) begin
                phase_nxt = P_IDLE;
                res_item  = mk_finish(ST_ERR_FLAGS, 32'h0);
              end else begin
                phase_nxt = P_FL_RD2;
                res_item  = mk_access(1'b1, REG_FIFOLEVEL, 8'h00);
              end
            end
            P_FL_RD2: begin
              if ((rd == 8'h00) || (32'(rd) > FIFO_DEPTH)) begin
                phase_nxt = P_IDLE;
                res_item  = mk_finish(ST_BAD_LEVEL, 32'h0);
              end else begin
                fifo_count_nxt = rd[CW-1:0];
                phase_nxt      = P_CTRL_RD;
                res_item       = mk_access(1'b1, REG_CONTROL, 8'h00);
              end
            end
            P_CTRL_RD: begin
              received_bits_nxt = (32'(bits) > 32'd255) ? 8'hFF : 8'(bits);
              byte_index_nxt    = '0;
              phase_nxt         = P_DATA_RD;
              res_item          = mk_access(1'b1, REG_FIFODATA, 8'h00);
            end
            P_DATA_RD: begin
              byte_index_nxt = index_inc[CW-1:0];
              if (index_inc < {1'b0, fifo_count_r}) begin
                res_item = mk_access(1'b1, REG_FIFODATA, 8'h00);
              end else if (!anticoll_r) begin
                if (received_bits_r < REQA_MIN_BITS) begin
                  phase_nxt = P_IDLE;
                  res_item  = mk_finish(ST_FEW_BITS, 32'h0);
                end else begin
                  anticoll_nxt = 1'b1;
                  phase_nxt    = P_BF_SET;
                  res_item     = mk_access(1'b0, REG_BITFRAME, BITFRAME_FULL);
                end
              end else begin
                phase_nxt = P_IDLE;
                if (received_bits_r < UID_MIN_BITS) begin
                  res_item = mk_finish(ST_FEW_BITS, 32'h0);
                end else if (chk != buf_view[4]) begin
                  res_item = mk_finish(ST_BAD_CHECK, 32'h0);
                end else begin
                  res_item = mk_finish(ST_OK,
                                       {buf_view[0], buf_view[1], buf_view[2], buf_view[3]});
                end
              end
            end
            default: begin
              // Idle or waiting for a tick: drop the request
              res_valid = 1'b0;
            end
          endcase
        end
        default: begin
          res_valid = 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for rfid_uid_read_sequencer_top: plays the reader chip on the
// request channel, predicts every register access and UID verdict, checks each result.
// Depends on rus_pkg and the sequencer RTL.
`timescale 1ns / 1ps

module tb_top;
  import rus_pkg::*;

  localparam int FIFO_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_wdata = '0;

  rfid_uid_read_sequencer_top #(.FIFO_DEPTH(FIFO_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // Sequencer state as predicted
  phase_t      seq_phase = P_IDLE;
  logic        seq_stage = 1'b0;
  logic [7:0]  seq_poll_limit = POLL_LIMIT_RESET;
  logic [7:0]  seq_polls = '0;
  logic [4:0]  seq_byte_idx = '0;
  logic [4:0]  seq_fifo_count = '0;
  logic [7:0]  seq_rx_bits = '0;
  logic [7:0]  seq_modify = '0;
  logic [7:0]  seq_reply [FIFO_DEPTH];

  out_item_t   next_access;
  bit          next_fired;
  bit          next_acted;
  out_item_t   pending_accesses [$];

  int          acted_count = 0;
  int          mismatches = 0;
  int unsigned cycles = 0;

  // Traffic shaping and card behavior
  int          send_gap_pct = 34;
  int          recv_stall_pct = 77;
  int          irq_hit_pct = 35;
  int          err_pct = 6;
  int          bad_level_pct = 6;
  int          short_pct = 6;
  int          bad_bcc_pct = 12;
  int          noise_pct = 5;
  logic [31:0] planned_uid;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("** rfid_uid_read_sequencer_top: FAILED **");
      $finish;
    end
  end

  function automatic bit chance(input int pct);
    return $urandom_range(99) < pct;
  endfunction

  task automatic issue_access(input phase_t nxt, input logic rd, input logic [5:0] regn,
                              input logic [7:0] data);
    seq_phase = nxt;
    next_fired = 1'b1;
    next_access = '0;
    next_access.kind = rd ? KIND_READ : KIND_WRITE;
    next_access.addr_byte = (({2'b00, regn} << 1) & 8'h7E) | (rd ? 8'h80 : 8'h00);
    next_access.write_data = rd ? 8'h00 : data;
  endtask

  task automatic issue_verdict(input logic [2:0] code, input logic [31:0] uid);
    seq_phase = P_IDLE;
    next_fired = 1'b1;
    next_access = '0;
    next_access.kind = KIND_FINISH;
    next_access.success = (code == ST_OK);
    next_access.status = code;
    next_access.card_uid = (code == ST_OK) ? uid : 32'h0;
  endtask

  task automatic issue_poll();
    if (seq_polls < seq_poll_limit) issue_access(P_IRQ_RD, 1'b1, REG_COMIRQ, 8'h00);
    else issue_access(P_BF_RD2, 1'b1, REG_BITFRAME, 8'h00);
  endtask

  task automatic close_transceive();
    logic [7:0] bcc;
    if (!seq_stage) begin
      if (seq_rx_bits < REQA_MIN_BITS) begin
        issue_verdict(ST_FEW_BITS, '0);
      end else begin
        seq_stage = 1'b1;
        issue_access(P_BF_SET, 1'b0, REG_BITFRAME, BITFRAME_FULL);
      end
    end else if (seq_rx_bits < UID_MIN_BITS) begin
      issue_verdict(ST_FEW_BITS, '0);
    end else begin
      bcc = seq_reply[0] ^ seq_reply[1] ^ seq_reply[2] ^ seq_reply[3];
      if (bcc != seq_reply[4]) issue_verdict(ST_BAD_CHECK, '0);
      else issue_verdict(ST_OK, {seq_reply[0], seq_reply[1], seq_reply[2], seq_reply[3]});
    end
  endtask

  // Advance the predicted sequencer by one accepted request.
  task automatic predict_next_access(input in_item_t req);
    logic [7:0] rd;
    logic [7:0] last;
    int         bits;
    rd = req.read_data;
    next_fired = 1'b0;
    case (req.command)
      CMD_START: begin
        if (seq_phase == P_IDLE) begin
          seq_stage = 1'b0;
          seq_polls = '0;
          seq_byte_idx = '0;
          issue_access(P_BF_SET, 1'b0, REG_BITFRAME, BITFRAME_SHORT);
        end
      end
      CMD_TICK: begin
        if (seq_phase == P_TICK) issue_poll();
      end
      CMD_DONE: begin
        case (seq_phase)
          P_BF_SET:   issue_access(P_CMD_IDLE, 1'b0, REG_COMMAND, CMD_IDLE_BYTE);
          P_CMD_IDLE: issue_access(P_IRQ_CLR, 1'b0, REG_COMIRQ, IRQ_CLEAR_ALL);
          P_IRQ_CLR:  issue_access(P_FL_RD, 1'b1, REG_FIFOLEVEL, 8'h00);
          P_FL_RD: begin
            seq_modify = rd | FLUSH_BIT;
            issue_access(P_FL_WR, 1'b0, REG_FIFOLEVEL, seq_modify);
          end
          P_FL_WR: begin
            seq_byte_idx = 5'd1;
            issue_access(P_DATA_WR, 1'b0, REG_FIFODATA, seq_stage ? SEL_CL1_BYTE : REQA_BYTE);
          end
          P_DATA_WR: begin
            if (seq_stage && seq_byte_idx < 5'd2) begin
              seq_byte_idx++;
              issue_access(P_DATA_WR, 1'b0, REG_FIFODATA, NVB_BYTE);
            end else begin
              issue_access(P_CMD_TX, 1'b0, REG_COMMAND, CMD_TRANSCEIVE);
            end
          end
          P_CMD_TX: issue_access(P_BF_RD1, 1'b1, REG_BITFRAME, 8'h00);
          P_BF_RD1: begin
            seq_modify = rd | 8'h80;
            issue_access(P_BF_WR1, 1'b0, REG_BITFRAME, seq_modify);
          end
          P_BF_WR1: begin
            seq_polls = '0;
            issue_poll();
          end
          P_IRQ_RD: begin
            if ((rd & IRQ_RX_IDLE) != 0) begin
              issue_access(P_BF_RD2, 1'b1, REG_BITFRAME, 8'h00);
            end else begin
              if (seq_polls < POLL_COUNT_MAX) seq_polls++;
              seq_phase = P_TICK;
              next_acted = 1'b1;
            end
          end
          P_BF_RD2: begin
            seq_modify = rd & START_SEND_MASK;
            issue_access(P_BF_WR2, 1'b0, REG_BITFRAME, seq_modify);
          end
          P_BF_WR2: issue_access(P_ERR_RD, 1'b1, REG_ERROR, 8'h00);
          P_ERR_RD: begin
            if ((rd & ERR_MASK) != 0) issue_verdict(ST_ERR_FLAGS, '0);
            else issue_access(P_FL_RD2, 1'b1, REG_FIFOLEVEL, 8'h00);
          end
          P_FL_RD2: begin
            if (rd == 0 || int'(rd) > FIFO_DEPTH) begin
              issue_verdict(ST_BAD_LEVEL, '0);
            end else begin
              seq_fifo_count = rd[4:0];
              issue_access(P_CTRL_RD, 1'b1, REG_CONTROL, 8'h00);
            end
          end
          P_CTRL_RD: begin
            last = rd & LAST_BITS_MASK;
            bits = int'(seq_fifo_count) * 8 - ((last != 0) ? 8 - int'(last) : 0);
            seq_rx_bits = (bits > 255) ? 8'd255 : 8'(bits);
            seq_byte_idx = '0;
            issue_access(P_DATA_RD, 1'b1, REG_FIFODATA, 8'h00);
          end
          P_DATA_RD: begin
            if (int'(seq_byte_idx) < FIFO_DEPTH) seq_reply[seq_byte_idx] = rd;
            seq_byte_idx++;
            if (seq_byte_idx < seq_fifo_count) issue_access(P_DATA_RD, 1'b1, REG_FIFODATA, 8'h00);
            else close_transceive();
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (next_fired) next_acted = 1'b1;
  endtask

  // Byte the reader chip returns for the access the sequencer is waiting on.
  function automatic logic [7:0] chip_reply();
    logic [7:0] b;
    logic [7:0] bcc;
    b = 8'($urandom);
    case (seq_phase)
      P_IRQ_RD: begin
        if (!chance(irq_hit_pct)) b = b & ~IRQ_RX_IDLE;
        else if ((b & IRQ_RX_IDLE) == 0) b[4 + $urandom_range(1)] = 1'b1;
      end
      P_ERR_RD: begin
        if (!chance(err_pct)) b = b & ~ERR_MASK;
        else if ((b & ERR_MASK) == 0) b = b | 8'h08;
      end
      P_FL_RD2: begin
        if (chance(bad_level_pct)) b = chance(50) ? 8'h00 : 8'($urandom_range(255, FIFO_DEPTH + 1));
        else if (chance(short_pct)) b = 8'($urandom_range(FIFO_DEPTH, 1));
        else b = seq_stage ? 8'd5 : 8'd2;
      end
      P_CTRL_RD: begin
        if (!chance(short_pct)) b = b & ~LAST_BITS_MASK;
      end
      P_DATA_RD: begin
        if (seq_stage && seq_byte_idx < 5'd4) begin
          b = 8'(planned_uid >> (24 - 8 * int'(seq_byte_idx)));
        end else if (seq_stage && seq_byte_idx == 5'd4) begin
          bcc = planned_uid[31:24] ^ planned_uid[23:16] ^ planned_uid[15:8] ^ planned_uid[7:0];
          b = chance(bad_bcc_pct) ? bcc ^ 8'($urandom_range(255, 1)) : bcc;
        end
      end
      default: ;
    endcase
    return b;
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [7:0] rd);
    in_item_t req;
    req.command = cmd;
    req.read_data = rd;
    while (chance(send_gap_pct)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    next_acted = 1'b0;
    predict_next_access(req);
    if (next_fired) pending_accesses.push_back(next_access);
    if (next_acted) acted_count++;
  endtask

  // A request the sequencer must drop in its current state.
  task automatic send_noise();
    logic [1:0] cmd;
    case ($urandom_range(2))
      0: cmd = CMD_UNUSED;
      1: cmd = (seq_phase == P_TICK || seq_phase == P_IDLE) ? CMD_DONE : CMD_TICK;
      default: cmd = (seq_phase == P_IDLE) ? CMD_TICK : CMD_START;
    endcase
    send_request(cmd, 8'($urandom));
  endtask

  task automatic drain_and_idle();
    in_valid <= 1'b0;
    while (pending_accesses.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_poll_limit(input logic [7:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    seq_poll_limit = value;
  endtask

  task automatic run_uid_read();
    planned_uid = $urandom;
    send_request(CMD_START, 8'($urandom));
    while (seq_phase != P_IDLE) begin
      if (chance(noise_pct)) send_noise();
      send_request(seq_phase == P_TICK ? CMD_TICK : CMD_DONE, chip_reply());
    end
  endtask

  task automatic test_ignored_requests();
    send_request(CMD_DONE, 8'hFF);
    send_request(CMD_TICK, 8'h00);
    send_request(CMD_UNUSED, 8'hA5);
    drain_and_idle();
  endtask

  // Reset poll limit, flag seen on the first poll, then the error register reports a fault.
  task automatic test_error_flags_at_reset_limit();
    irq_hit_pct = 100;
    err_pct = 100;
    send_request(CMD_START, 8'h00);
    send_request(CMD_START, 8'hFF);
    send_request(CMD_TICK, 8'h00);
    while (seq_phase != P_IDLE)
      send_request(seq_phase == P_TICK ? CMD_TICK : CMD_DONE, chip_reply());
    irq_hit_pct = 35;
    err_pct = 6;
    drain_and_idle();
  endtask

  task automatic test_random_reads(input int gap_pct, input int stall_pct, input int n_items);
    int target;
    send_gap_pct = gap_pct;
    recv_stall_pct = stall_pct;
    target = acted_count + n_items;
    while (acted_count < target) begin
      if (chance(30)) begin
        drain_and_idle();
        case ($urandom_range(6))
          0: write_poll_limit(8'd0);
          1: write_poll_limit(8'd1);
          2: write_poll_limit(8'd255);
          3: write_poll_limit(8'($urandom_range(255, 1)));
          4: write_poll_limit(POLL_LIMIT_RESET);
          default: write_poll_limit(8'($urandom_range(4, 1)));
        endcase
      end
      if (chance(15)) send_noise();
      run_uid_read();
    end
    drain_and_idle();
  endtask

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_accesses.size() == 0) begin
        $error("result with nothing expected: kind %0d addr_byte %02h",
               out_data.kind, out_data.addr_byte);
        mismatches++;
      end else begin
        want = pending_accesses.pop_front();
        if (out_data.kind !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_data.kind);
          mismatches++;
        end
        if (out_data.addr_byte !== want.addr_byte) begin
          $error("addr_byte: expected %02h, got %02h", want.addr_byte, out_data.addr_byte);
          mismatches++;
        end
        if (out_data.write_data !== want.write_data) begin
          $error("write_data: expected %02h, got %02h", want.write_data, out_data.write_data);
          mismatches++;
        end
        if (out_data.success !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, out_data.success);
          mismatches++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_data.status);
          mismatches++;
        end
        if (out_data.card_uid !== want.card_uid) begin
          $error("card_uid: expected %08h, got %08h", want.card_uid, out_data.card_uid);
          mismatches++;
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_ignored_requests();
    test_error_flags_at_reset_limit();
    test_random_reads(34, 77, 180);
    test_random_reads(77, 34, 180);
    test_random_reads(0, 0, 180);
    if (mismatches == 0) begin
      $display("** rfid_uid_read_sequencer_top: PASSED **");
    end else begin
      $display("** rfid_uid_read_sequencer_top: FAILED **");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/rus_pkg.sv
design/rus_ctrl.sv
design/rfid_uid_read_sequencer_top.sv
tb/tb_top.sv
